@@ design/bsi_pkg.sv @@
// Package for the bounded sorted insert block: beat types, cell type and constants.
// No dependencies; used by bsi_cell and bounded_sorted_insert_top_k.
package bsi_pkg;

    localparam int unsigned SECS_PER_MIN = 60;
    // Largest key is 1023*60+63, which fits in 16 bits.
    localparam int unsigned KEY_W  = 16;
    localparam int unsigned RANK_W = 5;

    // Input beat.
    typedef struct packed {
        logic [15:0] player_tag;
        logic [9:0]  minutes;
        logic [5:0]  seconds;
        logic [31:0] logged_at;
    } in_item_t;

    // Result beat.
    typedef struct packed {
        logic              accepted;
        logic [RANK_W-1:0] rank;
        logic [15:0]       out_tag;
        logic [9:0]        out_minutes;
        logic [5:0]        out_seconds;
        logic [31:0]       out_stamp;
        logic              is_new;
        logic              last;
    } result_t;

    // Contents of one list cell.
    typedef struct packed {
        logic             valid;
        logic             is_new;
        logic [KEY_W-1:0] key;
        logic [9:0]       minutes;
        logic [5:0]       seconds;
        logic [15:0]      tag;
        logic [31:0]      stamp;
    } cell_t;

    // Commands broadcast from the sequencer to every cell.
    typedef struct packed {
        logic insert;
        logic rotate;
    } cell_ctrl_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_SCAN
    } seq_state_t;

endpackage

@@ design/bsi_cell.sv @@
// One cell of the sorted list: holds an entry, inserts or shifts on command.
// Depends on bsi_pkg.
module bsi_cell
    import bsi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  cell_t      new_entry,
    input  cell_t      prev_cell,
    input  logic       prev_gt,
    input  cell_t      next_cell,
    output cell_t      held_entry,
    output logic       gt
);

    cell_t cell_reg;
    cell_t cell_next;

    // This cell lies past the insertion point when it is empty or holds a larger key.
    assign gt         = !cell_reg.valid || (cell_reg.key > new_entry.key);
    assign held_entry = cell_reg;

    // Insertion shifts the tail down by one; rotation moves the list up toward cell zero.
    always_comb
    begin
        cell_next = cell_reg;
        if (ctrl.insert)
        begin
            if (prev_gt)
            begin
                cell_next        = prev_cell;
                cell_next.is_new = 1'b0;
            end
            else if (gt)
            begin
                cell_next        = new_entry;
                cell_next.valid  = 1'b1;
                cell_next.is_new = 1'b1;
            end
            else
            begin
                cell_next.is_new = 1'b0;
            end
        end
        else if (ctrl.rotate)
        begin
            cell_next = next_cell;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

endmodule

@@ design/bounded_sorted_insert_top_k.sv @@
// Top level of the bounded sorted insert block: sequencer, cell chain, result register.
// Depends on bsi_pkg and bsi_cell.
//
// Usage: an item beat is taken at a rising edge with start high and busy low.
// Every cell compares its key with the new key at once, so the entry is placed
// in the list at that same edge; entries after it shift down one cell, and a
// full list drops its last entry.
// A rejected item gives one result beat, with accepted low and last high, in
// the next cycle; busy stays low and a new item may follow at once.
// An accepted item starts a scan: the chain rotates toward cell zero once a
// cycle until every cell has passed cell zero, and each valid entry leaving
// cell zero is registered as a result beat. Results appear in the cycle after
// the scan step, ranks 1 to n in consecutive cycles, last high on the final
// one. busy stays high for the whole scan, so no new item is taken until it
// ends; the full rotation, which returns the list to its order, sets its length.
// Each result is on the ports for exactly one cycle, marked by result_strobe;
// the receiver cannot stall.
// Reset empties the list and returns the sequencer to idle.
module bounded_sorted_insert_top_k
    import bsi_pkg::*;
#(
    parameter int unsigned SLOTS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  in_item_t item,
    output logic     result_strobe,
    output result_t  result
);

    localparam int unsigned CNT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    seq_state_t        state_reg;
    seq_state_t        state_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              strobe_reg;
    logic              strobe_next;
    result_t           result_reg;
    result_t           result_next;

    cell_t             cells [SLOTS];
    logic              gt [SLOTS];
    cell_t             new_entry;
    cell_ctrl_t        ctrl;
    logic              accept;
    logic              reject;
    logic [31:0]       rank_wide;

    // Key of the incoming entry.
    always_comb
    begin
        new_entry         = '0;
        new_entry.valid   = 1'b1;
        new_entry.is_new  = 1'b1;
        new_entry.key     = KEY_W'(item.minutes) * KEY_W'(SECS_PER_MIN)
                          + KEY_W'(item.seconds);
        new_entry.minutes = item.minutes;
        new_entry.seconds = item.seconds;
        new_entry.tag     = item.player_tag;
        new_entry.stamp   = item.logged_at;
    end

    // A full list keeps the entry only if its key is below the last key.
    assign busy        = (state_reg != SEQ_IDLE);
    assign accept      = start && !busy;
    assign reject      = accept && cells[SLOTS-1].valid && !gt[SLOTS-1];
    assign ctrl.insert = accept && !reject;
    assign ctrl.rotate = (state_reg == SEQ_SCAN);

    // Chain of cells; the last cell wraps to the first for rotation.
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        cell_t prev_c;
        logic  prev_g;
        if (i == 0)
        begin : g_head
            assign prev_c = '0;
            assign prev_g = 1'b0;
        end
        else
        begin : g_body
            assign prev_c = cells[i-1];
            assign prev_g = gt[i-1];
        end

        bsi_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .new_entry  (new_entry),
            .prev_cell  (prev_c),
            .prev_gt    (prev_g),
            .next_cell  (cells[(i + 1) % SLOTS]),
            .held_entry (cells[i]),
            .gt         (gt[i])
        );
    end

    assign rank_wide = 32'(cnt_reg) + 32'd1;

    // Sequencer and result beat selection.
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        strobe_next = 1'b0;
        result_next = '0;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (reject)
                begin
                    strobe_next      = 1'b1;
                    result_next.last = 1'b1;
                end
                else if (ctrl.insert)
                begin
                    state_next = SEQ_SCAN;
                    cnt_next   = '0;
                end
            end
            SEQ_SCAN:
            begin
                strobe_next             = cells[0].valid;
                result_next.accepted    = 1'b1;
                result_next.rank        = rank_wide[RANK_W-1:0];
                result_next.out_tag     = cells[0].tag;
                result_next.out_minutes = cells[0].minutes;
                result_next.out_seconds = cells[0].seconds;
                result_next.out_stamp   = cells[0].stamp;
                result_next.is_new      = cells[0].is_new;
                if (cnt_reg == CNT_W'(SLOTS - 1))
                begin
                    result_next.last = 1'b1;
                    state_next       = SEQ_IDLE;
                end
                else
                begin
                    result_next.last = !cells[1].valid;
                    cnt_next         = cnt_reg + CNT_W'(1);
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= SEQ_IDLE;
            cnt_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

`ifndef ASSERT_OFF
    // A rejected item always closes its run with a single beat.
    a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !result.accepted |-> result.last)
        else $error("rejected beat without last");

    // Only an accepted entry can be flagged as new.
    a_new_accepted: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.is_new |-> result.accepted)
        else $error("new flag on rejected beat");

    // Listed entries come only from scan steps.
    a_list_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && result.accepted |-> $past(busy))
        else $error("list beat outside a scan");

    // A full list never loses its last valid entry except through an insertion.
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        cells[SLOTS-1].valid && !busy && !start |=> cells[SLOTS-1].valid)
        else $error("list lost an entry while idle");
`endif

endmodule
